### src/atsp_pkg.sv
// ----------------------------------------------------------------------------
// atsp_pkg: shared constants and types for the tilt to screen point unit
// Holds the CORDIC angle table, the widths of the datapath and the stage types.
// ----------------------------------------------------------------------------
package atsp_pkg;

   localparam int unsigned SCREEN_WIDTH  = 128;
   localparam int unsigned SCREEN_HEIGHT = 160;
   localparam int unsigned CORDIC_STEPS  = 19;

   // sum of squares of two 12-bit values fits in 24 bits; shifted by 16 -> 40
   localparam int unsigned SQ_W   = 24;
   localparam int unsigned RAD_W  = 40;   // radicand, even width
   localparam int unsigned ROOT_W = 20;   // sqrt result
   localparam int unsigned CX_W   = 24;   // CORDIC x/y width, signed
   localparam int unsigned ACC_W  = 21;   // angle accumulator, signed

   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] idx);
      case (idx)
         5'd0:    atan_entry = 21'sd131072;
         5'd1:    atan_entry = 21'sd77376;
         5'd2:    atan_entry = 21'sd40884;
         5'd3:    atan_entry = 21'sd20753;
         5'd4:    atan_entry = 21'sd10417;
         5'd5:    atan_entry = 21'sd5213;
         5'd6:    atan_entry = 21'sd2607;
         5'd7:    atan_entry = 21'sd1304;
         5'd8:    atan_entry = 21'sd652;
         5'd9:    atan_entry = 21'sd326;
         5'd10:   atan_entry = 21'sd163;
         5'd11:   atan_entry = 21'sd81;
         5'd12:   atan_entry = 21'sd41;
         5'd13:   atan_entry = 21'sd20;
         5'd14:   atan_entry = 21'sd10;
         5'd15:   atan_entry = 21'sd5;
         5'd16:   atan_entry = 21'sd3;
         5'd17:   atan_entry = 21'sd1;
         5'd18:   atan_entry = 21'sd1;
         default: atan_entry = 21'sd0;
      endcase
   endfunction

   // one angle's worth of work in flight through the CORDIC
   typedef struct packed {
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero;
   } cordic_type;

endpackage

### src/atsp_sqrt.sv
// ----------------------------------------------------------------------------
// atsp_sqrt: pipelined integer square root
// One result bit per stage, ROOT_W stages; advances when enable is high.
// ----------------------------------------------------------------------------
module atsp_sqrt (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [atsp_pkg::RAD_W-1:0]       radicand,
   output logic [atsp_pkg::ROOT_W-1:0]      root
);
   localparam int unsigned N = atsp_pkg::ROOT_W;
   localparam int unsigned W = atsp_pkg::RAD_W;

   logic [W-1:0]   rem_ff  [N+1];
   logic [N-1:0]   res_ff  [N+1];
   logic [W-1:0]   rad_ff  [N+1];

   always_comb begin
      rem_ff[0] = '0;
      res_ff[0] = '0;
      rad_ff[0] = radicand;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [W-1:0] rem_in;
      logic [W-1:0] trial;
      logic [N-1:0] res_in;
      logic [W-1:0] rad_in;
      always_comb begin
         rem_in = {rem_ff[s][W-3:0], rad_ff[s][W-1:W-2]};
         trial  = {{(W-N-2){1'b0}}, res_ff[s], 2'b01};
         rad_in = {rad_ff[s][W-3:0], 2'b00};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            res_in = {res_ff[s][N-2:0], 1'b1};
         end else begin
            res_in = {res_ff[s][N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1] <= rem_in;
            res_ff[s+1] <= res_in;
            rad_ff[s+1] <= rad_in;
         end
      end
   end

   assign root = res_ff[N];
endmodule

### src/atsp_cordic.sv
// ----------------------------------------------------------------------------
// atsp_cordic: unrolled CORDIC vectoring pipeline
// One rotation per stage; output is the rounded and clamped binary angle.
// ----------------------------------------------------------------------------
module atsp_cordic (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [atsp_pkg::ROOT_W-1:0]        den,
   input  logic signed [11:0]                 num,
   output logic signed [15:0]                 angle
);
   localparam int unsigned N = atsp_pkg::CORDIC_STEPS;

   atsp_pkg::cordic_type st_ff [N+1];
   logic signed [15:0]   angle_ff;

   always_comb begin
      st_ff[0].x    = $signed({{(atsp_pkg::CX_W-atsp_pkg::ROOT_W){1'b0}}, den});
      st_ff[0].y    = $signed({{(atsp_pkg::CX_W-20){num[11]}}, num, 8'h00});
      st_ff[0].acc  = '0;
      st_ff[0].zero = (den == '0) && (num == '0);
   end

   for (genvar s = 0; s < N; s++) begin : g_rot
      atsp_pkg::cordic_type st_in;
      logic signed [atsp_pkg::CX_W-1:0] dx;
      logic signed [atsp_pkg::CX_W-1:0] dy;
      always_comb begin
         dx = st_ff[s].y >>> s;
         dy = st_ff[s].x >>> s;
         st_in = st_ff[s];
         if (!st_ff[s].y[atsp_pkg::CX_W-1]) begin
            st_in.x   = st_ff[s].x + dx;
            st_in.y   = st_ff[s].y - dy;
            st_in.acc = st_ff[s].acc + atsp_pkg::atan_entry(5'(s));
         end else begin
            st_in.x   = st_ff[s].x - dx;
            st_in.y   = st_ff[s].y + dy;
            st_in.acc = st_ff[s].acc - atsp_pkg::atan_entry(5'(s));
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            st_ff[s+1] <= st_in;
         end
      end
   end

   // round to 32768 units per pi and clamp
   logic signed [atsp_pkg::ACC_W:0] rnd;
   logic signed [15:0]              angle_in;
   always_comb begin
      rnd = ($signed({st_ff[N].acc[atsp_pkg::ACC_W-1], st_ff[N].acc}) + 22'sd8) >>> 4;
      if (st_ff[N].zero)            angle_in = 16'sd0;
      else if (rnd > 22'sd16384)    angle_in = 16'sd16384;
      else if (rnd < -22'sd16384)   angle_in = -16'sd16384;
      else                          angle_in = rnd[15:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;
endmodule

### src/atsp_marker.sv
// ----------------------------------------------------------------------------
// atsp_marker: angle to marker pixel
// Scales a binary angle to a screen coordinate, truncates and clamps; registered.
// ----------------------------------------------------------------------------
module atsp_marker (
   input  logic                clock,
   input  logic                enable,
   input  logic signed [15:0]  roll,
   input  logic signed [15:0]  pitch,
   output logic [6:0]          col,
   output logic [7:0]          row
);
   localparam int unsigned SW = atsp_pkg::SCREEN_WIDTH;
   localparam int unsigned SH = atsp_pkg::SCREEN_HEIGHT;

   logic signed [47:0] cnum;
   logic signed [47:0] rnum;
   logic signed [47:0] cpos;
   logic signed [47:0] rpos;
   logic [6:0] col_in, col_ff;
   logic [7:0] row_in, row_ff;

   always_comb begin
      cnum = 48'(longint'(SW / 2) * 32768) + 48'(longint'(roll) * longint'(SW));
      rnum = 48'(longint'(SH / 2) * 32768) + 48'(longint'(pitch) * longint'(SH));
      cpos = cnum >>> 15;
      rpos = rnum >>> 15;
      if (cnum < 0)                        col_in = '0;
      else if (cpos > 48'(longint'(SW) - 1)) col_in = 7'(SW - 1);
      else                                 col_in = cpos[6:0];
      if (rnum < 0)                        row_in = '0;
      else if (rpos > 48'(longint'(SH) - 1)) row_in = 8'(SH - 1);
      else                                 row_in = rpos[7:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;
endmodule

### src/accel_tilt_to_screen_point_unit.sv
// ----------------------------------------------------------------------------
// accel_tilt_to_screen_point_unit: accelerometer tilt to marker pixel
// Turns one raw accelerometer sample into pitch, roll and a screen position.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one sample per beat: x, y, z raw axis words. rsp_ returns one
//   beat per sample with pitch, roll (32768 units per pi) and the marker pixel.
//   Both channels use tvalid/tready; a beat moves when both are high.
// Pipeline and throughput:
//   One beat per cycle sustained unless the output stalls. The pipeline runs
//   from request beat to result beat through 1 input stage (divide and
//   square), 1 sum stage, 20 square root stages (one root bit each), 1
//   operand stage, 19 CORDIC rotations, 1 rounding stage and 1 marker
//   stage. The square root and CORDIC chains make up most of its depth.
// Stall:
//   The whole pipeline advances together. When rsp_tready is low while the
//   output stage holds a beat, hold every stage; req_tready drops only then,
//   so a stalled receiver still lets the pipeline advance until a beat reaches the output stage.
// Reset:
//   reset clears the valid bits; data registers keep whatever they had.
// ----------------------------------------------------------------------------
module accel_tilt_to_screen_point_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [15:0] pitch_angle, [31:16] roll_angle,
                                    // [38:32] marker_col, [46:39] marker_row, [47] zero
);
   localparam int unsigned LAT = 44;

   logic             enable;
   logic [LAT-1:0]   vld_ff;
   logic [LAT-1:0]   vld_in;

   // advance unless a result waits at the output
   assign enable     = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: divide by 16 toward zero, square
   logic signed [15:0] ax, ay, az;
   logic signed [11:0] dx_in, dy_in, dz_in;
   logic signed [11:0] dx_ff, dy_ff, dz_ff;
   logic [22:0] xx_ff, yy_ff, zz_ff;
   logic [22:0] xx_in, yy_in, zz_in;

   always_comb begin
      ax = req_tdata[15:0];
      ay = req_tdata[31:16];
      az = req_tdata[47:32];
      dx_in = ax[15] ? 12'(-((-17'(ax)) >>> 4)) : 12'(ax >>> 4);
      dy_in = ay[15] ? 12'(-((-17'(ay)) >>> 4)) : 12'(ay >>> 4);
      dz_in = az[15] ? 12'(-((-17'(az)) >>> 4)) : 12'(az >>> 4);
      xx_in = 23'(24'(dx_in * dx_in));
      yy_in = 23'(24'(dy_in * dy_in));
      zz_in = 23'(24'(dz_in * dz_in));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
      end
   end

   // stage 2: sums of squares; carry the numerators along with the root
   logic [atsp_pkg::SQ_W-1:0] sp_ff, sr_ff;
   logic signed [11:0] px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sp_ff <= {1'b0, yy_ff} + {1'b0, zz_ff};
         sr_ff <= {1'b0, xx_ff} + {1'b0, zz_ff};
         px_ff <= dx_ff;
         py_ff <= dy_ff;
      end
   end

   logic [atsp_pkg::ROOT_W-1:0] rp, rr;
   atsp_sqrt u_sqrt_p (
      .clock    (clock),
      .enable   (enable),
      .radicand ({sp_ff, 16'h0000}),
      .root     (rp)
   );
   atsp_sqrt u_sqrt_r (
      .clock    (clock),
      .enable   (enable),
      .radicand ({sr_ff, 16'h0000}),
      .root     (rr)
   );

   // delay numerators to match the root pipeline
   logic signed [11:0] nx_ff [atsp_pkg::ROOT_W];
   logic signed [11:0] ny_ff [atsp_pkg::ROOT_W];
   always_ff @(posedge clock) begin
      if (enable) begin
         nx_ff[0] <= px_ff;
         ny_ff[0] <= py_ff;
         for (int i = 1; i < atsp_pkg::ROOT_W; i++) begin
            nx_ff[i] <= nx_ff[i-1];
            ny_ff[i] <= ny_ff[i-1];
         end
      end
   end

   // operand stage ahead of the CORDIC
   logic [atsp_pkg::ROOT_W-1:0] dp_ff, dr_ff;
   logic signed [11:0]          np_ff, nr_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         dp_ff <= rp;
         dr_ff <= rr;
         np_ff <= nx_ff[atsp_pkg::ROOT_W-1];
         nr_ff <= ny_ff[atsp_pkg::ROOT_W-1];
      end
   end

   logic signed [15:0] pitch, roll;
   atsp_cordic u_cordic_p (
      .clock  (clock),
      .enable (enable),
      .den    (dp_ff),
      .num    (np_ff),
      .angle  (pitch)
   );
   atsp_cordic u_cordic_r (
      .clock  (clock),
      .enable (enable),
      .den    (dr_ff),
      .num    (nr_ff),
      .angle  (roll)
   );

   logic [6:0] col;
   logic [7:0] row;
   atsp_marker u_marker (
      .clock  (clock),
      .enable (enable),
      .roll   (roll),
      .pitch  (pitch),
      .col    (col),
      .row    (row)
   );

   // align the angles with the marker stage
   logic signed [15:0] pitch_ff, roll_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         pitch_ff <= pitch;
         roll_ff  <= roll;
      end
   end

   assign rsp_tdata = {1'b0, row, col, roll_ff, pitch_ff};
endmodule

### src/atsp_checker.sv
// ----------------------------------------------------------------------------
// atsp_checker: port-level checks for the tilt to screen point unit
// Watches result ranges and stall behavior at the top level's ports.
// ----------------------------------------------------------------------------
module atsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed under stall");

   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384 &&
                      $signed(rsp_tdata[15:0]) >= -16'sd16384))
      else $error("pitch out of range");

   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[46:39] < 8'd160)
      else $error("marker row beyond screen");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
endmodule

bind accel_tilt_to_screen_point_unit atsp_checker u_atsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/tb_accel_tilt_to_screen_point_unit.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_to_screen_point_unit: self-checking bench for the tilt unit
// Drives raw accelerometer samples, predicts pitch, roll and marker pixel with
// an independent integer CORDIC model, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_accel_tilt_to_screen_point_unit;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic        [6:0]  col;
      logic        [7:0]  row;
   } tilt_point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [15:0] pitch, [31:16] roll, [38:32] col, [46:39] row

   tilt_point_type expected_points[$];
   int          errors;
   int          send_idle_pct;
   int          recv_idle_pct;
   event        hold_off_start;
   logic        hold_off;

   accel_tilt_to_screen_point_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Arctangent table in 2^19 units per pi, kept locally.
   localparam longint ARC_TAB[19] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
      1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      for (longint b = longint'(1) << 21; b > 0; b = b >> 1)
         if ((r + b) * (r + b) <= v) r = r + b;
      return r;
   endfunction

   // Floor shift, independent of how the simulator shifts negatives.
   function automatic longint shr_floor(longint v, int s);
      if (v >= 0) return v >>> s;
      return -1 - ((-1 - v) >>> s);
   endfunction

   // atan2(n, sqrt(a^2+b^2)) in 32768 units per pi
   function automatic longint tilt_of(longint n, longint a, longint b);
      longint cx, cy, acc, dx, dy, r;
      cx  = root_floor((a * a + b * b) * 65536);
      cy  = n * 256;
      acc = 0;
      if (cx == 0 && cy == 0) return 0;
      for (int i = 0; i < 19; i++) begin
         dx = shr_floor(cy, i);
         dy = shr_floor(cx, i);
         if (cy >= 0) begin
            cx += dx; cy -= dy; acc += ARC_TAB[i];
         end else begin
            cx -= dx; cy += dy; acc -= ARC_TAB[i];
         end
      end
      r = shr_floor(acc + 8, 4);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic longint pixel_of(longint ang, longint size);
      longint num, pos;
      num = (size / 2) * 32768 + ang * size;
      if (num < 0) return 0;
      pos = num >>> 15;
      if (pos > size - 1) pos = size - 1;
      return pos;
   endfunction

   function automatic longint axis_scaled(logic [15:0] w);
      longint v;
      v = longint'($signed(w));
      return (v < 0) ? -((-v) / 16) : v / 16;
   endfunction

   function automatic tilt_point_type predict_point(logic [15:0] ax, logic [15:0] ay,
                                                    logic [15:0] az);
      tilt_point_type p;
      longint x, y, z, pa, ra;
      x = axis_scaled(ax);
      y = axis_scaled(ay);
      z = axis_scaled(az);
      pa = tilt_of(x, y, z);
      ra = tilt_of(y, x, z);
      p.pitch = pa[15:0];
      p.roll  = ra[15:0];
      p.col   = 7'(pixel_of(ra, atsp_pkg::SCREEN_WIDTH));
      p.row   = 8'(pixel_of(pa, atsp_pkg::SCREEN_HEIGHT));
      return p;
   endfunction

   // Offer one sample; random gaps before it, hold until the beat moves.
   task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_points.push_back(predict_point(ax, ay, az));
   endtask

   // Drain: drop valid, wait for all expectations, then an idle tail longer than the pipeline.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Long hold-off of the receiver, counted in cycles.
   initial begin
      hold_off = 1'b0;
      forever begin
         @(hold_off_start);
         hold_off <= 1'b1;
         repeat (150) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // Receiver: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result beat against the oldest expectation.
   always @(posedge clock) begin
      tilt_point_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[38:32], rsp_tdata[46:39]};
         if (expected_points.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = expected_points.pop_front();
            if (got.pitch !== want.pitch) begin
               $display("%0t pitch: expected %0d actual %0d", $time, want.pitch, got.pitch);
               errors++;
            end
            if (got.roll !== want.roll) begin
               $display("%0t roll: expected %0d actual %0d", $time, want.roll, got.roll);
               errors++;
            end
            if (got.col !== want.col) begin
               $display("%0t col: expected %0d actual %0d", $time, want.col, got.col);
               errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t row: expected %0d actual %0d", $time, want.row, got.row);
               errors++;
            end
         end
      end
   end

   // Extremes, zero vector, pure axes, truncation edges and clamping.
   task automatic test_directed();
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h000F, 16'hFFF1, 16'h0008);
      send_sample(16'h7FFF, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h7FFF, 16'h0000);
      send_sample(16'h0000, 16'h8000, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h7FFF);
      send_sample(16'h0000, 16'h0000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h8000, 16'h0000);
      send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
      send_sample(16'h0010, 16'hFFF0, 16'h0000);
      send_sample(16'hFFFF, 16'h0001, 16'hFFFF);
      send_sample(16'h5555, 16'hAAAA, 16'h5555);
      send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
      send_sample(16'h0010, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'hFFF0, 16'h0000);
      send_sample(16'h4000, 16'hC000, 16'h0010);
      wait_drained();
   endtask

   // Random samples: mostly full range, some small tilts near level.
   task automatic test_random(int count);
      logic [15:0] ax, ay, az;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            ax = 16'($urandom_range(2047)) - 16'd1024;
            ay = 16'($urandom_range(2047)) - 16'd1024;
            az = $urandom_range(1) ? 16'h4000 : 16'hC000;
         end else begin
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
         end
         send_sample(ax, ay, az);
      end
   endtask

   // Hold the receiver off long enough for the pipeline to fill and back up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      -> hold_off_start;
      test_random(80);
      wait_drained();
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 37;
      recv_idle_pct = 71;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(120);
      send_idle_pct = 71;
      recv_idle_pct = 37;
      test_random(120);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(120);
      wait_drained();
      test_backpressure();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
